@@ rtl/core/aeml_pkg.sv @@
// ----------------------------------------------------------------------------
// aeml_pkg
// Shared types, codes and lookup tables of the voice envelope and mix level
// block.
// ----------------------------------------------------------------------------
package aeml_pkg;

   // Command codes carried by one input item
   typedef enum logic [1:0] {
      CMD_NOTE_ON = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_SILENCE = 2'd3
   } cmd_type;

   // Envelope phases
   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_MUL3,
      ST_DIV3,
      ST_DONE
   } state_type;

   // Operand selection of the shared multiplier
   typedef enum logic [1:0] {
      MUL_VEL_CHAN,
      MUL_ENV,
      MUL_MASTER
   } mul_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        start;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_en;
      logic        mix_load;
      logic        out_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic mix_needed;
   } dp_status_type;

   // Divisor of every mix product
   localparam logic [14:0] MIX_DIVISOR = 15'd63;

   // Level step per speed index
   localparam logic [6:0] STEP_TAB [0:31] = '{
      7'd64, 7'd50, 7'd36, 7'd24, 7'd20, 7'd15, 7'd13, 7'd11,
      7'd9,  7'd8,  7'd7,  7'd6,  7'd5,  7'd10, 7'd4,  7'd3,
      7'd5,  7'd2,  7'd3,  7'd11, 7'd5,  7'd9,  7'd9,  7'd1,
      7'd2,  7'd3,  7'd7,  7'd5,  7'd4,  7'd3,  7'd3,  7'd2
   };

   // Ticks skipped between steps per speed index
   localparam logic [3:0] SKIP_TAB [0:31] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0,
      4'd1, 4'd0, 4'd1, 4'd7, 4'd2, 4'd5, 4'd7, 4'd0,
      4'd1, 4'd2, 4'd8, 4'd8, 4'd8, 4'd9, 4'd14, 4'd11
   };

   // Velocity curve, indexed by raw velocity / 2
   localparam logic [6:0] VEL_TAB [0:63] = '{
      7'd1,  7'd2,  7'd3,  7'd3,  7'd4,  7'd5,  7'd5,  7'd6,
      7'd7,  7'd8,  7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13,
      7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd20,
      7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28,
      7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36,
      7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd42,
      7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50,
      7'd52, 7'd53, 7'd55, 7'd57, 7'd58, 7'd60, 7'd62, 7'd64
   };

endpackage

@@ rtl/core/adsr_envelope_mix_level.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_mix_level
// Envelope and loudness of one synthesizer voice: note events and ticks in,
// one status item (mix level, envelope level, phase, active) out per command.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_stall   cmd, velocity, volume, speeds,
//                                             targets, loop_enable
//   rsp_     out        rsp_valid/rsp_stall   mix_level, env_level, env_phase,
//                                             voice_active
//   csr_     in         APB (psel/penable)    master_volume @0, play_enable @4
//
// A tick of an active voice does the envelope step and the first multiply on
// acceptance, then divide, multiply, divide, multiply, divide over one shared
// 8x8 multiplier and one divide-by-63 unit, then the result load. Every other
// command goes straight to the result load. One item is in work at a time; a
// new item is accepted while the previous result waits in the output register.
// A stalled result holds the block in its result stage. Reset is synchronous
// and clears all voice state; master_volume resets to 15, play_enable to 1.
// ----------------------------------------------------------------------------
module adsr_envelope_mix_level (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [6:0]        req_velocity,
   input  logic [5:0]        req_channel_volume,
   input  logic [4:0]        req_attack_speed,
   input  logic [5:0]        req_attack_target,
   input  logic [4:0]        req_decay_speed,
   input  logic [5:0]        req_decay_target,
   input  logic [4:0]        req_release_speed,
   input  logic              req_loop_enable,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_mix_level,
   output logic signed [7:0] rsp_env_level,
   output logic [1:0]        rsp_env_phase,
   output logic              rsp_voice_active,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import aeml_pkg::*;

   logic [3:0]    master_volume_q_ff;
   logic          play_enable_ff;
   logic          csr_write;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Register port: one register per word, selected by address bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_volume_q_ff <= 4'd15;
         play_enable_ff     <= 1'b1;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            play_enable_ff <= csr_pwdata[0];
         end else begin
            master_volume_q_ff <= csr_pwdata[3:0];
         end
      end
   end

   // Read back; low address bits are ignored by the decode
   assign csr_prdata = csr_paddr[2] ? {31'b0, play_enable_ff}
                                    : {28'b0, master_volume_q_ff};

   aeml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   aeml_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .master_volume      (master_volume_q_ff),
      .play_enable        (play_enable_ff),
      .req_cmd            (req_cmd),
      .req_velocity       (req_velocity),
      .req_channel_volume (req_channel_volume),
      .req_attack_speed   (req_attack_speed),
      .req_attack_target  (req_attack_target),
      .req_decay_speed    (req_decay_speed),
      .req_decay_target   (req_decay_target),
      .req_release_speed  (req_release_speed),
      .req_loop_enable    (req_loop_enable),
      .rsp_mix_level      (rsp_mix_level),
      .rsp_env_level      (rsp_env_level),
      .rsp_env_phase      (rsp_env_phase),
      .rsp_voice_active   (rsp_voice_active)
   );

endmodule

@@ rtl/core/aeml_ctrl.sv @@
// ----------------------------------------------------------------------------
// aeml_ctrl
// Sequencer of the envelope block: owns the input and result handshakes and
// steps the datapath through the three multiply / divide rounds of a tick.
// ----------------------------------------------------------------------------
module aeml_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output aeml_pkg::dp_cmd_type   dp_cmd,
   input  aeml_pkg::dp_status_type dp_status
);
   import aeml_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = dp_status.mix_needed ? ST_DIV1 : ST_DONE;
            end
         end
         ST_DIV1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_DIV2;
         ST_DIV2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_DIV3;
         ST_DIV3: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      dp_cmd          = '0;
      dp_cmd.mul_sel  = MUL_VEL_CHAN;
      case (state_ff)
         ST_IDLE: begin
            dp_cmd.start  = accept;
            dp_cmd.mul_en = accept;
         end
         ST_DIV1: dp_cmd.div_en = 1'b1;
         ST_MUL2: begin
            dp_cmd.mul_en  = 1'b1;
            dp_cmd.mul_sel = MUL_ENV;
         end
         ST_DIV2: dp_cmd.div_en = 1'b1;
         ST_MUL3: begin
            dp_cmd.mul_en  = 1'b1;
            dp_cmd.mul_sel = MUL_MASTER;
         end
         ST_DIV3: begin
            dp_cmd.div_en   = 1'b1;
            dp_cmd.mix_load = 1'b1;
         end
         ST_DONE: dp_cmd.out_load = slot_free;
         default: dp_cmd = '0;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A tick of an active voice enters the divide rounds
   a_tick_to_div : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && dp_status.mix_needed) |=> (state_ff == ST_DIV1))
      else $error("active tick did not start the mix rounds");

   // A result is never written over one that is still held
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // Last divide round hands over to the result stage
   a_div3_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV3) |=> (state_ff == ST_DONE))
      else $error("last divide round not followed by result stage");

endmodule

@@ rtl/core/aeml_dpath.sv @@
// ----------------------------------------------------------------------------
// aeml_dpath
// Envelope state, note latches, shared multiplier, divide-by-63 unit and
// result registers of the envelope block.
// ----------------------------------------------------------------------------
module aeml_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  aeml_pkg::dp_cmd_type    dp_cmd,
   output aeml_pkg::dp_status_type dp_status,
   input  logic [3:0]              master_volume,
   input  logic                    play_enable,
   input  logic [1:0]              req_cmd,
   input  logic [6:0]              req_velocity,
   input  logic [5:0]              req_channel_volume,
   input  logic [4:0]              req_attack_speed,
   input  logic [5:0]              req_attack_target,
   input  logic [4:0]              req_decay_speed,
   input  logic [5:0]              req_decay_target,
   input  logic [4:0]              req_release_speed,
   input  logic                    req_loop_enable,
   output logic [6:0]              rsp_mix_level,
   output logic signed [7:0]       rsp_env_level,
   output logic [1:0]              rsp_env_phase,
   output logic                    rsp_voice_active
);
   import aeml_pkg::*;

   // Voice state
   logic              active_ff,        active_in;
   logic              released_ff,      released_in;
   phase_type         phase_ff,         phase_in;
   logic signed [7:0] level_ff,         level_in;
   logic [3:0]        skip_ff,          skip_in;
   logic [6:0]        note_velocity_ff, note_velocity_in;
   logic [4:0]        held_attack_speed_ff;
   logic [5:0]        held_attack_target_ff;
   logic [4:0]        held_decay_speed_ff;
   logic [5:0]        held_decay_target_ff;
   logic [4:0]        held_release_speed_ff;
   logic              held_loop_ff;
   logic [6:0]        held_mix_ff;

   // Mix arithmetic
   logic              chan_nz_ff;
   logic [13:0]       prod_ff;
   logic              prod_neg_ff;
   logic [7:0]        quo_ff;

   // Envelope step helpers
   cmd_type           cmd;
   phase_type         run_phase;
   logic [4:0]        speed;
   logic [6:0]        step;
   logic signed [7:0] level_up;
   logic signed [7:0] level_dn;
   logic signed [7:0] attack_level;
   logic signed [7:0] decay_level;

   assign cmd          = cmd_type'(req_cmd);
   assign run_phase    = released_ff ? PH_RELEASE : phase_ff;
   assign attack_level = $signed({2'b00, held_attack_target_ff});
   assign decay_level  = $signed({2'b00, held_decay_target_ff});

   always_comb begin
      case (run_phase)
         PH_ATTACK: speed = held_attack_speed_ff;
         PH_DECAY:  speed = held_decay_speed_ff;
         default:   speed = held_release_speed_ff;
      endcase
   end

   assign step     = STEP_TAB[speed];
   assign level_up = level_ff + $signed({1'b0, step});
   assign level_dn = level_ff - $signed({1'b0, step});

   assign dp_status.mix_needed = (cmd == CMD_TICK) && active_ff;

   // Command decode and envelope step
   always_comb begin
      active_in        = active_ff;
      released_in      = released_ff;
      phase_in         = phase_ff;
      level_in         = level_ff;
      skip_in          = skip_ff;
      note_velocity_in = note_velocity_ff;
      case (cmd)
         CMD_NOTE_ON: begin
            active_in        = 1'b1;
            released_in      = 1'b0;
            phase_in         = PH_ATTACK;
            level_in         = '0;
            skip_in          = '0;
            note_velocity_in = (req_velocity != '0) ? VEL_TAB[req_velocity[6:1]] : '0;
         end
         CMD_RELEASE: begin
            if (active_ff) begin
               released_in = 1'b1;
               skip_in     = '0;
            end
         end
         CMD_TICK: begin
            if (active_ff) begin
               if (!held_loop_ff) begin
                  level_in = attack_level;
               end else begin
                  phase_in = run_phase;
                  if (run_phase == PH_SUSTAIN) begin
                     level_in = decay_level;
                  end else if (skip_ff != '0) begin
                     skip_in = skip_ff - 4'd1;
                  end else begin
                     skip_in = SKIP_TAB[speed];
                     case (run_phase)
                        PH_ATTACK: begin
                           if (level_up >= attack_level) begin
                              level_in = attack_level;
                              phase_in = PH_DECAY;
                           end else begin
                              level_in = level_up;
                           end
                        end
                        PH_DECAY: begin
                           if (level_dn <= decay_level) begin
                              level_in = decay_level;
                              phase_in = PH_SUSTAIN;
                           end else begin
                              level_in = level_dn;
                           end
                        end
                        default: begin
                           // release at or below zero silences the voice
                           level_in = level_dn;
                           if (level_dn <= 8'sd0) begin
                              active_in        = 1'b0;
                              released_in      = 1'b0;
                              phase_in         = PH_ATTACK;
                              skip_in          = '0;
                              note_velocity_in = '0;
                           end
                        end
                     endcase
                  end
               end
            end
         end
         default: begin
            // silence: level and mix level are kept
            active_in        = 1'b0;
            released_in      = 1'b0;
            phase_in         = PH_ATTACK;
            skip_in          = '0;
            note_velocity_in = '0;
         end
      endcase
   end

   // Shared multiplier operands
   logic [7:0]  mul_a;
   logic [7:0]  mul_b;
   logic [7:0]  level_abs;
   logic [15:0] mul_p;

   assign level_abs = level_ff[7] ? 8'(-level_ff) : 8'(level_ff);

   always_comb begin
      case (dp_cmd.mul_sel)
         MUL_VEL_CHAN: begin
            mul_a = {1'b0, note_velocity_ff};
            mul_b = {2'b00, req_channel_volume};
         end
         MUL_ENV: begin
            mul_a = quo_ff;
            mul_b = level_abs;
         end
         MUL_MASTER: begin
            mul_a = quo_ff;
            mul_b = {2'b00, master_volume, 2'b00};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Divide by 63: estimate from x/64 + x/4096, then one correction step
   logic [14:0] div_sum;
   logic [8:0]  div_est;
   logic [14:0] div_rem;
   logic [8:0]  div_q;
   logic [7:0]  div_res;

   assign div_sum = {1'b0, prod_ff} + {7'b0, prod_ff[13:6]};
   assign div_est = div_sum[14:6];
   assign div_rem = {1'b0, prod_ff} - (({6'b0, div_est} << 6) - {6'b0, div_est});
   assign div_q   = (div_rem >= MIX_DIVISOR) ? (div_est + 9'd1) : div_est;
   // truncation toward zero: negate the magnitude quotient
   assign div_res = prod_neg_ff ? 8'(-div_q) : div_q[7:0];

   // Final mix level with floor of one and the zero cases
   logic       mix_gate;
   logic [6:0] mix_value;

   assign mix_gate  = chan_nz_ff && (note_velocity_ff != '0) && (level_ff != '0) &&
                      (master_volume != '0) && play_enable;
   assign mix_value = !mix_gate ? 7'd0 : (div_q == '0) ? 7'd1 : div_q[6:0];

   // Voice state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff             <= 1'b0;
         released_ff           <= 1'b0;
         phase_ff              <= PH_ATTACK;
         level_ff              <= '0;
         skip_ff               <= '0;
         note_velocity_ff      <= '0;
         held_attack_speed_ff  <= '0;
         held_attack_target_ff <= '0;
         held_decay_speed_ff   <= '0;
         held_decay_target_ff  <= '0;
         held_release_speed_ff <= '0;
         held_loop_ff          <= 1'b0;
         held_mix_ff           <= '0;
      end else begin
         if (dp_cmd.start) begin
            active_ff        <= active_in;
            released_ff      <= released_in;
            phase_ff         <= phase_in;
            level_ff         <= level_in;
            skip_ff          <= skip_in;
            note_velocity_ff <= note_velocity_in;
            if (cmd == CMD_NOTE_ON) begin
               held_attack_speed_ff  <= req_attack_speed;
               held_attack_target_ff <= req_attack_target;
               held_decay_speed_ff   <= req_decay_speed;
               held_decay_target_ff  <= req_decay_target;
               held_release_speed_ff <= req_release_speed;
               held_loop_ff          <= req_loop_enable;
               held_mix_ff           <= '0;
            end
         end
         if (dp_cmd.mix_load) begin
            held_mix_ff <= mix_value;
         end
      end
   end

   // Mix arithmetic registers
   always_ff @(posedge clock) begin
      if (dp_cmd.start) begin
         chan_nz_ff <= (req_channel_volume != '0);
      end
      if (dp_cmd.mul_en) begin
         prod_ff     <= mul_p[13:0];
         prod_neg_ff <= (dp_cmd.mul_sel == MUL_ENV) && level_ff[7];
      end
      if (dp_cmd.div_en) begin
         quo_ff <= div_res;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         rsp_mix_level    <= held_mix_ff;
         rsp_env_level    <= level_ff;
         rsp_env_phase    <= phase_ff;
         rsp_voice_active <= active_ff;
      end
   end

   // A silent voice holds no velocity
   a_idle_no_vel : assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (note_velocity_ff == '0))
      else $error("inactive voice keeps a velocity");

   // Release only marks a sounding voice
   a_rel_active : assert property (@(posedge clock) disable iff (reset)
      released_ff |-> active_ff)
      else $error("released flag set on a silent voice");

   // Sustain sits on the decay target
   a_sustain_level : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SUSTAIN) |-> (level_ff == decay_level))
      else $error("sustain level differs from decay target");

endmodule

@@ dv/tb_adsr_envelope_mix_level.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_mix_level
// Self-checking bench for one voice's envelope and mix level. A scoreboard
// class keeps its own copy of the voice state and registers, predicts the
// status item of every accepted command and compares the block's status items
// in order. Stimulus is a short directed run of corner cases, then random note
// sequences (note_on, ticks, release, ticks) with random noise commands, under
// several master volume and play settings, bursty input and random output
// stall.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_mix_level;
   import aeml_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_QUOTA = 190;
   localparam int PRINT_LIMIT = 100;

   // register byte addresses
   localparam logic [2:0] ADDR_MASTER_VOLUME = 3'd0;
   localparam logic [2:0] ADDR_PLAY_ENABLE   = 3'd4;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // one command item
   typedef struct {
      cmd_type    cmd;
      logic [6:0] velocity;
      logic [5:0] channel_volume;
      logic [4:0] attack_speed;
      logic [5:0] attack_target;
      logic [4:0] decay_speed;
      logic [5:0] decay_target;
      logic [4:0] release_speed;
      logic       loop_enable;
   } voice_cmd_type;

   // one status item
   typedef struct {
      logic [6:0] mix_level;
      logic [7:0] env_level;
      phase_type  env_phase;
      logic       voice_active;
   } voice_status_type;

   // -------------------------------------------------------------------------
   // Scoreboard: voice state, registers and the queue of expected status items
   // -------------------------------------------------------------------------
   class envelope_scoreboard;
      int        step_lut[32];
      int        skip_lut[32];
      int        vel_lut[64];
      int        master_vol;
      int        play_on;
      bit        active;
      bit        released;
      phase_type phase;
      int        level;
      int        skip_count;
      int        note_vel;
      int        hold_att_spd, hold_att_tgt, hold_dec_spd, hold_dec_tgt;
      int        hold_rel_spd;
      bit        hold_loop;
      int        hold_mix;
      voice_status_type pending_status[$];
      int        mismatches;
      int        results_seen;

      function new();
         step_lut = '{64, 50, 36, 24, 20, 15, 13, 11, 9, 8, 7, 6, 5, 10, 4, 3,
                      5, 2, 3, 11, 5, 9, 9, 1, 2, 3, 7, 5, 4, 3, 3, 2};
         skip_lut = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0,
                      1, 0, 1, 7, 2, 5, 7, 0, 1, 2, 8, 8, 8, 9, 14, 11};
         vel_lut  = '{1, 2, 3, 3, 4, 5, 5, 6, 7, 8, 8, 9, 10, 11, 12, 13,
                      14, 15, 16, 17, 18, 19, 20, 20, 21, 22, 23, 24, 25, 26, 27, 28,
                      29, 30, 31, 32, 33, 34, 35, 36, 36, 37, 38, 39, 40, 41, 42, 42,
                      43, 44, 45, 46, 47, 48, 49, 50, 52, 53, 55, 57, 58, 60, 62, 64};
         master_vol   = 15;
         play_on      = 1;
         active       = 0;
         released     = 0;
         phase        = PH_ATTACK;
         level        = 0;
         skip_count   = 0;
         note_vel     = 0;
         hold_att_spd = 0;
         hold_att_tgt = 0;
         hold_dec_spd = 0;
         hold_dec_tgt = 0;
         hold_rel_spd = 0;
         hold_loop    = 0;
         hold_mix     = 0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void set_register(logic [2:0] addr, logic [31:0] data);
         if (addr == ADDR_MASTER_VOLUME)
            master_vol = int'(data[3:0]);
         else if (addr == ADDR_PLAY_ENABLE)
            play_on = int'(data[0]);
      endfunction

      // level arithmetic wraps at 8 bits, two's complement
      function int wrap8(int x);
         byte b;
         b = byte'(x);
         return int'(b);
      endfunction

      function void silence();
         active     = 0;
         note_vel   = 0;
         released   = 0;
         phase      = PH_ATTACK;
         skip_count = 0;
      endfunction

      // one envelope tick
      function void step_envelope();
         int spd;
         if (!hold_loop) begin
            level = hold_att_tgt;
            return;
         end
         if (released)
            phase = PH_RELEASE;
         if (phase == PH_SUSTAIN) begin
            level = hold_dec_tgt;
            return;
         end
         if (skip_count != 0) begin
            skip_count--;
            return;
         end
         case (phase)
            PH_ATTACK: spd = hold_att_spd;
            PH_DECAY:  spd = hold_dec_spd;
            default:   spd = hold_rel_spd;
         endcase
         skip_count = skip_lut[spd];
         case (phase)
            PH_ATTACK: begin
               level = wrap8(level + step_lut[spd]);
               if (level >= hold_att_tgt) begin
                  level = hold_att_tgt;
                  phase = PH_DECAY;
               end
            end
            PH_DECAY: begin
               level = wrap8(level - step_lut[spd]);
               if (level <= hold_dec_tgt) begin
                  level = hold_dec_tgt;
                  phase = PH_SUSTAIN;
               end
            end
            default: begin
               level = wrap8(level - step_lut[spd]);
               if (level <= 0)
                  silence();
            end
         endcase
      endfunction

      // velocity * channel * envelope * master, each product over 63
      function void update_mix(int chan);
         int v;
         v = note_vel;
         if (chan == 0) begin
            v = 0;
         end else if (v != 0) begin
            v = (v * chan / 63) & 255;
            if (level != 0) begin
               v = ((v * level) / 63) & 255;
               if (master_vol != 0) begin
                  v = (v * (master_vol * 4) / 63) & 255;
                  // floor: everything nonzero never mixes to silence
                  if (v == 0)
                     v = 1;
               end else begin
                  v = 0;
               end
            end else begin
               v = 0;
            end
         end
         if (play_on == 0)
            v = 0;
         hold_mix = v & 127;
      endfunction

      // accepted command: advance the voice and queue its status item
      function void note_command(voice_cmd_type c);
         voice_status_type want;
         case (c.cmd)
            CMD_NOTE_ON: begin
               released     = 0;
               level        = 0;
               phase        = PH_ATTACK;
               skip_count   = 0;
               hold_att_spd = int'(c.attack_speed);
               hold_att_tgt = int'(c.attack_target);
               hold_dec_spd = int'(c.decay_speed);
               hold_dec_tgt = int'(c.decay_target);
               hold_rel_spd = int'(c.release_speed);
               hold_loop    = c.loop_enable;
               note_vel     = (c.velocity != 0) ? vel_lut[c.velocity >> 1] : 0;
               active       = 1;
               hold_mix     = 0;
            end
            CMD_RELEASE: begin
               if (active) begin
                  released   = 1;
                  skip_count = 0;
               end
            end
            CMD_TICK: begin
               if (active) begin
                  step_envelope();
                  update_mix(int'(c.channel_volume));
               end
            end
            default: silence();
         endcase
         want.mix_level    = 7'(hold_mix);
         want.env_level    = 8'(level);
         want.env_phase    = phase;
         want.voice_active = active;
         pending_status.insert(pending_status.size(), want);
      endfunction

      task report_mismatch(string what, int got, int want);
         if (mismatches < PRINT_LIMIT)
            $display("%0t status item %0d: %s got %0d want %0d",
                     $time, results_seen, what, got, want);
         mismatches++;
      endtask

      // compare one status item with the oldest expectation
      task check_status(voice_status_type got);
         voice_status_type want;
         if (pending_status.size() == 0) begin
            report_mismatch("status item with none expected, mix_level",
                            int'(got.mix_level), 0);
         end else begin
            want = pending_status.pop_front();
            if (got.mix_level !== want.mix_level)
               report_mismatch("mix_level", int'(got.mix_level), int'(want.mix_level));
            if (got.env_level !== want.env_level)
               report_mismatch("env_level", int'($signed(got.env_level)),
                               int'($signed(want.env_level)));
            if (got.env_phase !== want.env_phase)
               report_mismatch("env_phase", int'(got.env_phase), int'(want.env_phase));
            if (got.voice_active !== want.voice_active)
               report_mismatch("voice_active", int'(got.voice_active),
                               int'(want.voice_active));
         end
         results_seen++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and block
   // -------------------------------------------------------------------------
   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic [6:0]        req_velocity;
   logic [5:0]        req_channel_volume;
   logic [4:0]        req_attack_speed;
   logic [5:0]        req_attack_target;
   logic [4:0]        req_decay_speed;
   logic [5:0]        req_decay_target;
   logic [4:0]        req_release_speed;
   logic              req_loop_enable;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [6:0]        rsp_mix_level;
   logic signed [7:0] rsp_env_level;
   logic [1:0]        rsp_env_phase;
   logic              rsp_voice_active;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   envelope_scoreboard sb;
   voice_status_type   status_seen;
   int                 cycle_count;
   int                 items_counted;
   int                 burst_left;
   bit                 calm;

   adsr_envelope_mix_level dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_velocity       (req_velocity),
      .req_channel_volume (req_channel_volume),
      .req_attack_speed   (req_attack_speed),
      .req_attack_target  (req_attack_target),
      .req_decay_speed    (req_decay_speed),
      .req_decay_target   (req_decay_target),
      .req_release_speed  (req_release_speed),
      .req_loop_enable    (req_loop_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mix_level      (rsp_mix_level),
      .rsp_env_level      (rsp_env_level),
      .rsp_env_phase      (rsp_env_phase),
      .rsp_voice_active   (rsp_voice_active),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // clock, 12 ns period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // output stall, in a random pattern that changes after a random span
   initial begin
      stall_mode_type mode;
      int             span;
      int             k;
      rsp_stall = 1'b0;
      k = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 80);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((k % 5) < 2);
            endcase
            k++;
         end
      end
   end

   // status monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen.mix_level    = rsp_mix_level;
         status_seen.env_level    = rsp_env_level;
         status_seen.env_phase    = phase_type'(rsp_env_phase);
         status_seen.voice_active = rsp_voice_active;
         sb.check_status(status_seen);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // drive one item and wait until it is taken
   task automatic send_item(voice_cmd_type it);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_cmd            <= it.cmd;
      req_velocity       <= it.velocity;
      req_channel_volume <= it.channel_volume;
      req_attack_speed   <= it.attack_speed;
      req_attack_target  <= it.attack_target;
      req_decay_speed    <= it.decay_speed;
      req_decay_target   <= it.decay_target;
      req_release_speed  <= it.release_speed;
      req_loop_enable    <= it.loop_enable;
      do @(posedge clock); while (req_stall);
      sb.note_command(it);
   endtask

   // burst framing around send_item
   task automatic issue(voice_cmd_type it);
      if (it.cmd == CMD_NOTE_ON || sb.active)
         items_counted++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!calm)
            idle_req($urandom_range(0, 8));
      end
      burst_left--;
      send_item(it);
   endtask

   task automatic write_register(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(addr, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // stop sending and wait for every expected status item
   task automatic drain_status();
      idle_req(1);
      while (sb.pending_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(int volume, int play);
      drain_status();
      write_register(ADDR_MASTER_VOLUME, 32'(volume));
      write_register(ADDR_PLAY_ENABLE, 32'(play));
   endtask

   // -------------------------------------------------------------------------
   // Item builders
   // -------------------------------------------------------------------------
   function automatic voice_cmd_type cmd_item(cmd_type c, int chan);
      voice_cmd_type it;
      it.cmd            = c;
      it.velocity       = '0;
      it.channel_volume = 6'(chan);
      it.attack_speed   = '0;
      it.attack_target  = '0;
      it.decay_speed    = '0;
      it.decay_target   = '0;
      it.release_speed  = '0;
      it.loop_enable    = 1'b0;
      return it;
   endfunction

   function automatic voice_cmd_type note_on_item(int vel, int as, int at, int ds, int dt,
                                                  int rs, int lp);
      voice_cmd_type it;
      it                = cmd_item(CMD_NOTE_ON, 0);
      it.velocity       = 7'(vel);
      it.attack_speed   = 5'(as);
      it.attack_target  = 6'(at);
      it.decay_speed    = 5'(ds);
      it.decay_target   = 6'(dt);
      it.release_speed  = 5'(rs);
      it.loop_enable    = lp[0];
      return it;
   endfunction

   // half the speeds from the no-skip range so envelopes finish
   function automatic logic [4:0] pick_speed();
      return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 12))
                                         : 5'($urandom_range(0, 31));
   endfunction

   function automatic voice_cmd_type random_item(cmd_type c);
      voice_cmd_type it;
      it.cmd            = c;
      it.velocity       = 7'($urandom_range(0, 127));
      it.channel_volume = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
      it.attack_speed   = pick_speed();
      it.attack_target  = 6'($urandom_range(0, 63));
      it.decay_speed    = pick_speed();
      it.decay_target   = 6'($urandom_range(0, 63));
      it.release_speed  = pick_speed();
      it.loop_enable    = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // ticks with an occasional random command mixed in
   task automatic run_ticks(int n);
      voice_cmd_type it;
      repeat (n) begin
         if (!sb.active)
            break;
         if ($urandom_range(0, 11) == 0)
            it = random_item(cmd_type'($urandom_range(0, 3)));
         else
            it = random_item(CMD_TICK);
         issue(it);
      end
   endtask

   // note_on, ticks, release, ticks
   task automatic play_voice_sequence();
      voice_cmd_type it;
      calm = ($urandom_range(0, 3) == 0);
      it = random_item(CMD_NOTE_ON);
      if ($urandom_range(0, 9) < 8)
         it.loop_enable = 1'b1;
      issue(it);
      run_ticks($urandom_range(1, 40));
      if ($urandom_range(0, 9) != 0) begin
         issue(random_item(CMD_RELEASE));
         run_ticks($urandom_range(1, 60));
      end
      if ($urandom_range(0, 4) == 0)
         issue(random_item(CMD_SILENCE));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int volume_set[6];
      int play_set[6];
      sb = new();
      items_counted      = 0;
      burst_left         = 0;
      calm               = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = CMD_TICK;
      req_velocity       = '0;
      req_channel_volume = '0;
      req_attack_speed   = '0;
      req_attack_target  = '0;
      req_decay_speed    = '0;
      req_decay_target   = '0;
      req_release_speed  = '0;
      req_loop_enable    = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      volume_set = '{15, 0, 1, 15, 15, 8};
      play_set   = '{1, 1, 1, 0, 1, 1};
      volume_set[4] = $urandom_range(2, 14);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      apply_settings(volume_set[0], play_set[0]);

      // idle voice ignores ticks and releases
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_RELEASE, 0));
      issue(cmd_item(CMD_SILENCE, 0));
      // attack to a low peak, decay jumps up to a higher sustain level
      issue(note_on_item(127, 0, 10, 0, 50, 31, 1));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_TICK, 0));
      issue(cmd_item(CMD_TICK, 63));
      // repeated release, slow release with skip countdown, then silence
      issue(cmd_item(CMD_RELEASE, 0));
      issue(cmd_item(CMD_RELEASE, 0));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_SILENCE, 0));
      // zero velocity
      issue(note_on_item(0, 31, 63, 31, 0, 0, 1));
      issue(cmd_item(CMD_TICK, 63));
      // no loop: level follows attack target, mix floor, release never ends
      issue(note_on_item(1, 5, 63, 5, 0, 5, 0));
      issue(cmd_item(CMD_TICK, 1));
      issue(cmd_item(CMD_RELEASE, 0));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_TICK, 63));
      // release stepping below zero silences the voice
      issue(note_on_item(126, 0, 63, 0, 63, 0, 1));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_RELEASE, 0));
      issue(cmd_item(CMD_TICK, 63));
      issue(cmd_item(CMD_TICK, 63));

      // random note sequences under each register setting
      for (int p = 0; p < 6; p++) begin
         if (p != 0)
            apply_settings(volume_set[p], play_set[p]);
         items_counted = 0;
         while (items_counted < PHASE_QUOTA)
            play_voice_sequence();
      end

      drain_status();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/aeml_pkg.sv
rtl/core/aeml_ctrl.sv
rtl/core/aeml_dpath.sv
rtl/core/adsr_envelope_mix_level.sv
dv/tb_adsr_envelope_mix_level.sv
